/* rtl/dghb_pkg.sv */
// Shared types and constants of the detector grid hit binner.
package dghb_pkg;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_HIT   = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Register index codes, taken from paddr bit 2.
  localparam logic REG_HALF_WIDTH = 1'b0;

  // Reset value of the half-width register.
  localparam logic [8:0] HALF_WIDTH_RESET = 9'd50;

  // Particle code boundaries: the type is the code divided by 1000.
  localparam logic [19:0] CODE_T2 = 20'd2000;
  localparam logic [19:0] CODE_T3 = 20'd3000;
  localparam logic [19:0] CODE_T4 = 20'd4000;
  localparam logic [19:0] CODE_T5 = 20'd5000;
  localparam logic [19:0] CODE_T6 = 20'd6000;
  localparam logic [19:0] CODE_T7 = 20'd7000;

  // Counter lanes in the count memory word.
  localparam int LANES = 4;
  localparam int LANE_POSITRON = 0;
  localparam int LANE_ELECTRON = 1;
  localparam int LANE_MU_PLUS  = 2;
  localparam int LANE_MU_MINUS = 3;

  // Width of a count as it leaves the block.
  localparam int SHOW_W = 16;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  // One result word.
  typedef struct packed {
    logic [SHOW_W-1:0] positron_hits;
    logic [SHOW_W-1:0] electron_hits;
    logic [SHOW_W-1:0] muon_plus_hits;
    logic [SHOW_W-1:0] muon_minus_hits;
    logic [31:0]       first_time;
    logic              time_seen;
  } result_t;

endpackage

/* rtl/dghb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module dghb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read of the entry written at the same edge returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/detector_grid_hit_binner.sv */
// Detector grid hit binner: bins particle hits into per-detector counters and earliest times.
// A read word passes stage A, stage B and the result queue before it shows on the output.
// Throughput: one word per cycle; the memories are read one stage ahead and written back
// one stage later, with forwarding from the last write. A four-word result queue holds
// read results; input stalls only while queued plus in-flight reads would overflow it.
// Reset sets half_width_cm to 50 and clears the per-detector valid bits, so counts read zero.
module detector_grid_hit_binner #(
  parameter int GRID       = 10,
  parameter int PITCH_CM   = 1000,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [19:0]        particle_code_i,
  input  logic signed [23:0] pos_x_cm_i,
  input  logic signed [23:0] pos_y_cm_i,
  input  logic signed [31:0] hit_time_i,
  input  logic [6:0]         detector_sel_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        positron_hits_o,
  output logic [15:0]        electron_hits_o,
  output logic [15:0]        muon_plus_hits_o,
  output logic [15:0]        muon_minus_hits_o,
  output logic signed [31:0] first_time_o,
  output logic               time_seen_o
);

  localparam int NDET = GRID * GRID;
  localparam int AW   = $clog2(NDET);
  localparam int KW   = $clog2(GRID);
  localparam int RW   = dghb_pkg::LANES * COUNT_BITS;

  // Configuration register.
  logic [8:0] half_width_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == dghb_pkg::REG_HALF_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= dghb_pkg::HALF_WIDTH_RESET;
    end else if (cfg_we) begin
      half_width_q <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dghb_pkg::REG_HALF_WIDTH) begin
      prdata = {23'd0, half_width_q};
    end
  end

  // Input decode: particle type and the row and column squares that hold the hit.
  logic                         in_acc;
  dghb_pkg::cmd_e               cmd_in;
  logic [dghb_pkg::LANES-1:0]   bump_in;
  logic                         hit_type_in;
  logic [GRID-1:0]              row_in;
  logic [GRID-1:0]              col_in;
  logic [AW-1:0]                sel_in;
  logic                         sel_ok_in;
  logic [31:0]                  sel_wide;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cmd_in   = dghb_pkg::cmd_e'(cmd_i);
  assign sel_wide = 32'(detector_sel_i);
  assign sel_in   = sel_wide[AW-1:0];
  assign sel_ok_in = sel_wide < 32'(NDET);

  always_comb begin
    bump_in = '0;
    bump_in[dghb_pkg::LANE_POSITRON] =
        (particle_code_i >= dghb_pkg::CODE_T2) && (particle_code_i < dghb_pkg::CODE_T3);
    bump_in[dghb_pkg::LANE_ELECTRON] =
        (particle_code_i >= dghb_pkg::CODE_T3) && (particle_code_i < dghb_pkg::CODE_T4);
    bump_in[dghb_pkg::LANE_MU_PLUS] =
        (particle_code_i >= dghb_pkg::CODE_T5) && (particle_code_i < dghb_pkg::CODE_T6);
    bump_in[dghb_pkg::LANE_MU_MINUS] =
        (particle_code_i >= dghb_pkg::CODE_T6) && (particle_code_i < dghb_pkg::CODE_T7);
    hit_type_in =
        (particle_code_i >= dghb_pkg::CODE_T2) && (particle_code_i < dghb_pkg::CODE_T7);
  end

  // Each lane compares the doubled position against its doubled center plus or minus 2*hw.
  always_comb begin
    logic signed [33:0] px2;
    logic signed [33:0] py2;
    logic signed [33:0] hw2;
    logic signed [33:0] c2;
    px2 = 34'(pos_x_cm_i) <<< 1;
    py2 = 34'(pos_y_cm_i) <<< 1;
    hw2 = {24'd0, half_width_q, 1'b0};
    for (int k = 0; k < GRID; k++) begin
      c2 = 34'((2 * k - 2 * (GRID / 2) + 1) * PITCH_CM);
      col_in[k] = (px2 >= c2 - hw2) && (px2 <= c2 + hw2);
      row_in[k] = (py2 >= c2 - hw2) && (py2 <= c2 + hw2);
    end
  end

  // Stage A: decoded input word.
  logic                       a_valid_q;
  dghb_pkg::cmd_e             a_cmd_q;
  logic [dghb_pkg::LANES-1:0] a_bump_q;
  logic                       a_hit_q;
  logic signed [31:0]         a_time_q;
  logic [AW-1:0]              a_sel_q;
  logic                       a_sel_ok_q;
  logic [GRID-1:0]            a_row_q;
  logic [GRID-1:0]            a_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cmd_q    <= cmd_in;
      a_bump_q   <= bump_in;
      a_hit_q    <= hit_type_in;
      a_time_q   <= hit_time_i;
      a_sel_q    <= sel_in;
      a_sel_ok_q <= sel_ok_in;
      a_row_q    <= row_in;
      a_col_q    <= col_in;
    end
  end

  // Lowest row and lowest column win; the detector number addresses both memories.
  logic [KW-1:0] row_idx;
  logic [KW-1:0] col_idx;
  logic [AW-1:0] hit_addr;
  logic [AW-1:0] rd_addr;
  logic          a_do_hit;

  always_comb begin
    row_idx = '0;
    col_idx = '0;
    for (int k = GRID - 1; k >= 0; k--) begin
      if (a_row_q[k]) begin
        row_idx = KW'(k);
      end
      if (a_col_q[k]) begin
        col_idx = KW'(k);
      end
    end
  end

  assign hit_addr = AW'(row_idx) * AW'(GRID) + AW'(col_idx);
  assign a_do_hit = (a_cmd_q == dghb_pkg::CMD_HIT) && a_hit_q && (|a_row_q) && (|a_col_q);
  assign rd_addr  = (a_cmd_q == dghb_pkg::CMD_HIT) ? hit_addr : a_sel_q;

  // Stage B: memory data arrives, the entry is modified and written back.
  logic                       b_valid_q;
  dghb_pkg::cmd_e             b_cmd_q;
  logic [dghb_pkg::LANES-1:0] b_bump_q;
  logic                       b_do_hit_q;
  logic signed [31:0]         b_time_q;
  logic [AW-1:0]              b_addr_q;
  logic                       b_sel_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_cmd_q    <= a_cmd_q;
      b_bump_q   <= a_bump_q;
      b_do_hit_q <= a_do_hit;
      b_time_q   <= a_time_q;
      b_addr_q   <= rd_addr;
      b_sel_ok_q <= a_sel_ok_q;
    end
  end

  // Count and earliest-time memories.
  logic                     cnt_we;
  logic [RW-1:0]            cnt_wdata;
  logic [RW-1:0]            cnt_rdata;
  logic                     time_we;
  logic [31:0]              time_rdata;

  dghb_ram #(
    .WIDTH (RW),
    .DEPTH (NDET)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (b_addr_q),
    .wdata_i (cnt_wdata),
    .re_i    (a_valid_q),
    .raddr_i (rd_addr),
    .rdata_o (cnt_rdata)
  );

  dghb_ram #(
    .WIDTH (32),
    .DEPTH (NDET)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (b_addr_q),
    .wdata_i (b_time_q),
    .re_i    (a_valid_q),
    .raddr_i (rd_addr),
    .rdata_o (time_rdata)
  );

  // Per-detector valid bits and the last write, kept for forwarding.
  logic [NDET-1:0]    cnt_valid_q;
  logic [NDET-1:0]    ev_valid_q;
  logic               fwd_cnt_we_q;
  logic               fwd_time_we_q;
  logic [AW-1:0]      fwd_addr_q;
  logic [RW-1:0]      fwd_cnt_q;
  logic signed [31:0] fwd_time_q;

  logic                  addr_ok;
  logic                  fwd_hit;
  logic                  cv;
  logic                  ev;
  logic [RW-1:0]         cnt_cur;
  logic signed [31:0]    time_mem;
  logic                  time_upd;
  logic                  push;
  logic                  ev_clear;
  logic [COUNT_BITS-1:0] lane_cur [dghb_pkg::LANES];
  logic [15:0]           lane_show [dghb_pkg::LANES];
  dghb_pkg::result_t     res;

  assign addr_ok  = b_do_hit_q || b_sel_ok_q;
  assign fwd_hit  = fwd_addr_q == b_addr_q;
  assign cv       = addr_ok ? cnt_valid_q[b_addr_q] : 1'b0;
  assign ev       = addr_ok ? ev_valid_q[b_addr_q] : 1'b0;
  assign time_mem = (fwd_time_we_q && fwd_hit) ? fwd_time_q : $signed(time_rdata);
  assign time_upd = !ev || (b_time_q < time_mem);
  assign cnt_we   = b_valid_q && b_do_hit_q;
  assign time_we  = cnt_we && time_upd;
  assign push     = b_valid_q && (b_cmd_q == dghb_pkg::CMD_READ);
  assign ev_clear = b_valid_q && (b_cmd_q == dghb_pkg::CMD_EVENT);

  // Merge forwarded data, mask entries not written since reset or their last read, and bump the saturating counters.
  always_comb begin
    if (!cv) begin
      cnt_cur = '0;
    end else if (fwd_cnt_we_q && fwd_hit) begin
      cnt_cur = fwd_cnt_q;
    end else begin
      cnt_cur = cnt_rdata;
    end
    for (int i = 0; i < dghb_pkg::LANES; i++) begin
      lane_cur[i] = cnt_cur[i*COUNT_BITS +: COUNT_BITS];
      if (b_bump_q[i] && (lane_cur[i] != '1)) begin
        cnt_wdata[i*COUNT_BITS +: COUNT_BITS] = lane_cur[i] + COUNT_BITS'(1);
      end else begin
        cnt_wdata[i*COUNT_BITS +: COUNT_BITS] = lane_cur[i];
      end
    end
  end

  // Counts leave the block clipped to 16 bits.
  for (genvar i = 0; i < dghb_pkg::LANES; i++) begin : g_show
    if (COUNT_BITS > dghb_pkg::SHOW_W) begin : g_clip
      assign lane_show[i] = (|lane_cur[i][COUNT_BITS-1:dghb_pkg::SHOW_W]) ?
                            16'hFFFF : lane_cur[i][dghb_pkg::SHOW_W-1:0];
    end else begin : g_ext
      assign lane_show[i] = 16'(lane_cur[i]);
    end
  end

  always_comb begin
    res.positron_hits   = lane_show[dghb_pkg::LANE_POSITRON];
    res.electron_hits   = lane_show[dghb_pkg::LANE_ELECTRON];
    res.muon_plus_hits  = lane_show[dghb_pkg::LANE_MU_PLUS];
    res.muon_minus_hits = lane_show[dghb_pkg::LANE_MU_MINUS];
    res.first_time      = ev ? time_mem : 32'sd0;
    res.time_seen       = ev;
  end

  // Valid bits: hits set them, an event start clears all times, a read clears the counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_valid_q   <= '0;
      ev_valid_q    <= '0;
      fwd_cnt_we_q  <= 1'b0;
      fwd_time_we_q <= 1'b0;
    end else begin
      fwd_cnt_we_q  <= cnt_we;
      fwd_time_we_q <= time_we;
      if (cnt_we) begin
        cnt_valid_q[b_addr_q] <= 1'b1;
      end else if (push && b_sel_ok_q) begin
        cnt_valid_q[b_addr_q] <= 1'b0;
      end
      if (ev_clear) begin
        ev_valid_q <= '0;
      end else if (time_we) begin
        ev_valid_q[b_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      fwd_addr_q <= b_addr_q;
      fwd_cnt_q  <= cnt_wdata;
      fwd_time_q <= b_time_q;
    end
  end

  // Result queue.
  dghb_pkg::result_t            fifo_q [dghb_pkg::FIFO_DEPTH];
  logic [dghb_pkg::FIFO_PW-1:0] wr_ptr_q;
  logic [dghb_pkg::FIFO_PW-1:0] rd_ptr_q;
  logic [dghb_pkg::FIFO_CW-1:0] fifo_cnt_q;
  logic                         pop;
  logic [dghb_pkg::FIFO_CW:0]   credit_used;
  dghb_pkg::result_t            head;

  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + 1'b1;
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  // Reads in flight hold a queue slot from acceptance on.
  assign credit_used = (dghb_pkg::FIFO_CW + 1)'(fifo_cnt_q)
                     + (dghb_pkg::FIFO_CW + 1)'(a_valid_q && (a_cmd_q == dghb_pkg::CMD_READ))
                     + (dghb_pkg::FIFO_CW + 1)'(b_valid_q && (b_cmd_q == dghb_pkg::CMD_READ));
  assign in_stall_o  = credit_used >= (dghb_pkg::FIFO_CW + 1)'(dghb_pkg::FIFO_DEPTH);

  assign head              = fifo_q[rd_ptr_q];
  assign out_valid_o       = fifo_cnt_q != '0;
  assign positron_hits_o   = head.positron_hits;
  assign electron_hits_o   = head.electron_hits;
  assign muon_plus_hits_o  = head.muon_plus_hits;
  assign muon_minus_hits_o = head.muon_minus_hits;
  assign first_time_o      = $signed(head.first_time);
  assign time_seen_o       = head.time_seen;

  // Queued and in-flight reads never exceed the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_used <= (dghb_pkg::FIFO_CW + 1)'(dghb_pkg::FIFO_DEPTH))
    else $error("result queue credit overrun");

  // The queue never receives a word while full and not draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && (fifo_cnt_q == (dghb_pkg::FIFO_CW)'(dghb_pkg::FIFO_DEPTH))))
    else $error("result queue overflow");

  // An event start leaves no earliest time valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_clear |=> (ev_valid_q == '0))
    else $error("earliest times survive an event start");

  // A read of a real detector clears its counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && b_sel_ok_q) |=> !cnt_valid_q[$past(b_addr_q)])
    else $error("counts not cleared by a read");

endmodule

/* bench/detector_grid_hit_binner_test.sv */
// Self-checking testbench of the detector grid hit binner, with a scoreboard and drivers.
module detector_grid_hit_binner_test;

  localparam int GRID       = 10;
  localparam int PITCH_CM   = 1000;
  localparam int COUNT_BITS = 16;
  localparam int NDET       = GRID * GRID;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  // Cycles to let in-flight hits retire before the block counts as idle.
  localparam int SETTLE     = 4;
  // Rows and columns that random traffic favors, so counts build up between reads.
  localparam int HOT        = 4;
  localparam int PHASE_WORDS = 250;
  // Rounds of back-to-back hits on one detector, one hit per counter lane each round.
  localparam int BURST_ROUNDS = 16;

  // One input word as the sender presents it.
  typedef struct {
    dghb_pkg::cmd_e     cmd;
    logic [19:0]        code;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [31:0] t;
    logic [6:0]         sel;
  } bin_word_t;

  // Predicted per-detector state and the read results still owed by the block.
  class grid_tally;
    longint unsigned    pos_cnt [NDET];
    longint unsigned    ele_cnt [NDET];
    longint unsigned    mup_cnt [NDET];
    longint unsigned    mum_cnt [NDET];
    logic signed [31:0] early_t [NDET];
    bit                 early_ok [NDET];
    logic [8:0]         half_width;
    dghb_pkg::result_t  pending_reads [$];
    int                 mismatches;

    function new();
      foreach (pos_cnt[i]) begin
        pos_cnt[i] = 0;
        ele_cnt[i] = 0;
        mup_cnt[i] = 0;
        mum_cnt[i] = 0;
        early_t[i] = '0;
        early_ok[i] = 1'b0;
      end
      half_width = dghb_pkg::HALF_WIDTH_RESET;
      mismatches = 0;
    endfunction

    // Lowest grid index whose square holds the coordinate, or -1. Doubled
    // coordinates keep the half-pitch centers integral.
    function int slot_of(longint p);
      longint hw2;
      longint c2;
      longint d;
      hw2 = 2 * longint'(half_width);
      for (int k = 0; k < GRID; k++) begin
        c2 = longint'(2 * k - 2 * (GRID / 2) + 1) * PITCH_CM;
        d = 2 * p - c2;
        if (d <= hw2 && -d <= hw2) return k;
      end
      return -1;
    endfunction

    function longint unsigned bumped(longint unsigned c);
      return (c < CNT_MAX) ? c + 1 : c;
    endfunction

    function logic [dghb_pkg::SHOW_W-1:0] shown(longint unsigned c);
      return (c > {dghb_pkg::SHOW_W{1'b1}}) ? {dghb_pkg::SHOW_W{1'b1}} :
             c[dghb_pkg::SHOW_W-1:0];
    endfunction

    // Apply one accepted input word to the predicted state.
    function void note_word(bin_word_t w);
      int                row;
      int                col;
      int                d;
      dghb_pkg::result_t owed;
      case (w.cmd)
        dghb_pkg::CMD_HIT: begin
          if (w.code < dghb_pkg::CODE_T2 || w.code >= dghb_pkg::CODE_T7) return;
          row = slot_of(longint'(w.y));
          col = slot_of(longint'(w.x));
          if (row < 0 || col < 0) return;
          d = row * GRID + col;
          // Type 4 hits move the earliest time only.
          if (w.code < dghb_pkg::CODE_T3) pos_cnt[d] = bumped(pos_cnt[d]);
          else if (w.code < dghb_pkg::CODE_T4) ele_cnt[d] = bumped(ele_cnt[d]);
          else if (w.code >= dghb_pkg::CODE_T5 && w.code < dghb_pkg::CODE_T6)
            mup_cnt[d] = bumped(mup_cnt[d]);
          else if (w.code >= dghb_pkg::CODE_T6) mum_cnt[d] = bumped(mum_cnt[d]);
          if (!early_ok[d] || w.t < early_t[d]) begin
            early_t[d] = w.t;
            early_ok[d] = 1'b1;
          end
        end
        dghb_pkg::CMD_EVENT: begin
          foreach (early_ok[i]) early_ok[i] = 1'b0;
        end
        dghb_pkg::CMD_READ: begin
          owed = '0;
          // An out-of-range detector reads as all zero and clears nothing.
          if (w.sel < NDET) begin
            owed.positron_hits   = shown(pos_cnt[w.sel]);
            owed.electron_hits   = shown(ele_cnt[w.sel]);
            owed.muon_plus_hits  = shown(mup_cnt[w.sel]);
            owed.muon_minus_hits = shown(mum_cnt[w.sel]);
            if (early_ok[w.sel]) begin
              owed.first_time = early_t[w.sel];
              owed.time_seen  = 1'b1;
            end
            pos_cnt[w.sel] = 0;
            ele_cnt[w.sel] = 0;
            mup_cnt[w.sel] = 0;
            mum_cnt[w.sel] = 0;
          end
          pending_reads.push_back(owed);
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result word with the oldest owed read.
    function void check_read(dghb_pkg::result_t got);
      dghb_pkg::result_t want;
      if (pending_reads.size() == 0) begin
        $display("%0t: result word with no read pending, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = pending_reads.pop_front();
      check_field("positron_hits", want.positron_hits, got.positron_hits);
      check_field("electron_hits", want.electron_hits, got.electron_hits);
      check_field("muon_plus_hits", want.muon_plus_hits, got.muon_plus_hits);
      check_field("muon_minus_hits", want.muon_minus_hits, got.muon_minus_hits);
      check_field("first_time", want.first_time, got.first_time);
      check_field("time_seen", want.time_seen, got.time_seen);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i = '0;
  logic [19:0]        particle_code_i = '0;
  logic signed [23:0] pos_x_cm_i = '0;
  logic signed [23:0] pos_y_cm_i = '0;
  logic signed [31:0] hit_time_i = '0;
  logic [6:0]         detector_sel_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        positron_hits_o;
  logic [15:0]        electron_hits_o;
  logic [15:0]        muon_plus_hits_o;
  logic [15:0]        muon_minus_hits_o;
  logic signed [31:0] first_time_o;
  logic               time_seen_o;

  grid_tally         tally;
  dghb_pkg::result_t seen_word;
  bit                quiet = 1'b0;
  bit                out_took = 1'b0;
  int                stall_left = 0;
  logic [8:0]        hw_plan [6] = '{9'd0, 9'd499, 9'd500, 9'd0, 9'd511, 9'd50};
  logic [19:0]       lane_codes [4] = '{dghb_pkg::CODE_T2, dghb_pkg::CODE_T3,
                                        dghb_pkg::CODE_T5, dghb_pkg::CODE_T6};

  detector_grid_hit_binner #(
    .GRID       (GRID),
    .PITCH_CM   (PITCH_CM),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .particle_code_i   (particle_code_i),
    .pos_x_cm_i        (pos_x_cm_i),
    .pos_y_cm_i        (pos_y_cm_i),
    .hit_time_i        (hit_time_i),
    .detector_sel_i    (detector_sel_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .positron_hits_o   (positron_hits_o),
    .electron_hits_o   (electron_hits_o),
    .muon_plus_hits_o  (muon_plus_hits_o),
    .muon_minus_hits_o (muon_minus_hits_o),
    .first_time_o      (first_time_o),
    .time_seen_o       (time_seen_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Center of grid index k in cm.
  function automatic int center_cm(int k);
    return ((2 * k - 2 * (GRID / 2) + 1) * PITCH_CM) / 2;
  endfunction

  function automatic bin_word_t word_of(dghb_pkg::cmd_e c, int code, int x, int y,
                                        logic signed [31:0] t, int sel);
    bin_word_t w;
    w.cmd  = c;
    w.code = code[19:0];
    w.x    = x[23:0];
    w.y    = y[23:0];
    w.t    = t;
    w.sel  = sel[6:0];
    return w;
  endfunction

  // Offset from a center that lands on, just past, or anywhere near the square rim.
  function automatic int offset_near(int hw);
    case ($urandom_range(0, 11))
      0: return hw;
      1: return -hw;
      2: return hw + 1;
      3: return -hw - 1;
      default: return int'($urandom_range(0, 2 * hw + 6)) - (hw + 3);
    endcase
  endfunction

  // A hit of type 2 to 6 aimed at a detector, with a spread of times.
  function automatic bin_word_t random_hit();
    int                 row;
    int                 col;
    int                 hw;
    logic signed [31:0] t;
    hw  = tally.half_width;
    row = $urandom_range(0, 1) ? $urandom_range(0, HOT - 1) : $urandom_range(0, GRID - 1);
    col = $urandom_range(0, 1) ? $urandom_range(0, HOT - 1) : $urandom_range(0, GRID - 1);
    t   = $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 1000)) - 500;
    return word_of(dghb_pkg::CMD_HIT,
                   $urandom_range(dghb_pkg::CODE_T2, dghb_pkg::CODE_T7 - 1),
                   center_cm(col) + offset_near(hw), center_cm(row) + offset_near(hw),
                   t, $urandom);
  endfunction

  // Present one input word after a random gap (none while quiet) and hold it until accepted.
  task automatic send_word(bin_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    cmd_i           <= w.cmd;
    particle_code_i <= w.code;
    pos_x_cm_i      <= w.x;
    pos_y_cm_i      <= w.y;
    hit_time_i      <= w.t;
    detector_sel_i  <= w.sel;
    do @(posedge clk_i); while (in_stall_o);
    tally.note_word(w);
  endtask

  // Stop sending and wait for every owed read, then let trailing hits retire.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tally.pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the half-width register on an idle block; upper data bits are junk.
  task automatic write_half_width(logic [8:0] hw);
    logic [31:0] data;
    data = $urandom;
    data[8:0] = hw;
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {dghb_pkg::REG_HALF_WIDTH, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tally.half_width = hw;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mixed traffic: mostly aimed hits and reads, some noise, event starts and unused words.
  task automatic random_phase(int count);
    bin_word_t w;
    int        pick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == count / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 55) w = random_hit();
      else if (pick < 65)
        w = word_of(dghb_pkg::CMD_HIT, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 70)
        w = word_of(dghb_pkg::CMD_EVENT, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 92)
        w = word_of(dghb_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 1) ?
                    $urandom_range(0, HOT - 1) * GRID + $urandom_range(0, HOT - 1) :
                    $urandom_range(0, NDET - 1));
      else if (pick < 96)
        w = word_of(dghb_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 127));
      else w = word_of(dghb_pkg::CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_word(w);
    end
    quiet = 1'b0;
  endtask

  // Receiver stall: a fresh random hold-off after every accepted result word.
  always @(negedge clk_i) begin
    if (out_took) begin
      out_took = 1'b0;
      stall_left = quiet ? 0 : $urandom_range(0, 8);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_word.positron_hits   = positron_hits_o;
      seen_word.electron_hits   = electron_hits_o;
      seen_word.muon_plus_hits  = muon_plus_hits_o;
      seen_word.muon_minus_hits = muon_minus_hits_o;
      seen_word.first_time      = first_time_o;
      seen_word.time_seen       = time_seen_o;
      tally.check_read(seen_word);
      out_took = 1'b1;
    end
  end

  initial begin
    tally = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset half-width.
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T2, center_cm(0), center_cm(0),
                      100, 0));
    // Exactly on the inclusive rim, and one centimeter past it.
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T3 + 999, center_cm(0) + 50,
                      center_cm(0) - 50, -5, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T5, center_cm(0) + 51,
                      center_cm(0), -100, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T6, center_cm(9), center_cm(9),
                      32'h7FFF_FFFF, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T4, center_cm(9), center_cm(9),
                      32'h8000_0000, 0));
    // Particle types outside two to six.
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T2 - 1, center_cm(0), center_cm(0),
                      -900, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T7, center_cm(0), center_cm(0),
                      -900, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, 20'hF_FFFF, center_cm(0), center_cm(0), -900, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, 20'h0, center_cm(0), center_cm(0), -900, 0));
    // Hits far off the grid.
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T2, -8388608, 8388607, -900, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T5, 8388607, -8388608, -900, 0));
    send_word(word_of(dghb_pkg::CMD_NONE, 20'hF_FFFF, -1, -1, -1, 7'h7F));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 99));
    // Detector numbers past the grid.
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, NDET));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 127));
    send_word(word_of(dghb_pkg::CMD_EVENT, 0, 0, 0, 0, 0));
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T5 + 500, center_cm(5), center_cm(5),
                      7, 0));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 55));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 99));

    // Overlapping squares: a hit on the shared rim goes to the lowest row and column.
    write_half_width(9'd511);
    send_word(word_of(dghb_pkg::CMD_HIT, dghb_pkg::CODE_T6, -4000, -4000, 3, 0));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, 1));

    // Back-to-back hits on one detector keep the forwarding path busy.
    quiet = 1'b1;
    for (int r = 0; r < BURST_ROUNDS; r++) begin
      foreach (lane_codes[j])
        send_word(word_of(dghb_pkg::CMD_HIT, lane_codes[j], center_cm(1), center_cm(1),
                          $urandom, 0));
    end
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, GRID + 1));
    send_word(word_of(dghb_pkg::CMD_READ, 0, 0, 0, 0, GRID + 1));
    quiet = 1'b0;

    // Random traffic under a sequence of half-width settings.
    hw_plan[3] = 9'($urandom_range(1, 498));
    foreach (hw_plan[p]) begin
      write_half_width(hw_plan[p]);
      random_phase(PHASE_WORDS);
    end

    // Drain, with a bound, then report.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int n = 0; n < 2000 && tally.pending_reads.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE * 2) @(posedge clk_i);
    if (tally.pending_reads.size() != 0) begin
      $display("%0t: %0d read results never arrived", $time, tally.pending_reads.size());
      tally.mismatches++;
    end
    if (tally.mismatches == 0) begin
      $display("detector_grid_hit_binner_test: PASS");
    end else begin
      $display("detector_grid_hit_binner_test: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("detector_grid_hit_binner_test: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/dghb_pkg.sv
rtl/dghb_ram.sv
rtl/detector_grid_hit_binner.sv
bench/detector_grid_hit_binner_test.sv
